FILE: hw/rtl/mbmc_pkg.sv
// Shared types, constants and helpers for the manual button mode controller.
// Used by mbmc_front, mbmc_queue, mbmc_back and manual_button_mode_controller_core.
package mbmc_pkg;

   localparam int DIRECTIONS_DEF = 4;
   localparam int QUEUE_DEPTH    = 2;
   localparam int MAX_BEATS      = 3;

   localparam logic [5:0]  FRAME_MANUAL = 6'h2;
   localparam logic [13:0] SECS_PER_MIN = 14'd60;
   localparam logic [13:0] IDLE_MAX     = 14'h3FFF;
   localparam logic [31:0] DIR_LAMPS    = 32'h7;
   localparam logic [7:0]  TIMEOUT_RST  = 8'd5;

   // Register byte addresses
   localparam logic [2:0] ADDR_TIMEOUT = 3'h0;

   typedef enum logic [3:0] {
      ACT_ENTER      = 4'd0,
      ACT_FLASH      = 4'd1,
      ACT_ALL_RED    = 4'd2,
      ACT_STEP       = 4'd3,
      ACT_STAGE      = 4'd4,
      ACT_DIR        = 4'd5,
      ACT_SPECIAL    = 4'd6,
      ACT_AUTO       = 4'd7,
      ACT_STEP_GREEN = 4'd8,
      ACT_STEP_AMBER = 4'd9,
      ACT_DIR_GREEN  = 4'd10,
      ACT_DIR_AMBER  = 4'd11
   } action_type;

   typedef enum logic [7:0] {
      MODE_AUTO    = 8'b0000_0001,
      MODE_MANUAL  = 8'b0000_0010,
      MODE_FLASH   = 8'b0000_0100,
      MODE_RED     = 8'b0000_1000,
      MODE_STEP    = 8'b0001_0000,
      MODE_STAGE   = 8'b0010_0000,
      MODE_DIR     = 8'b0100_0000,
      MODE_SPECIAL = 8'b1000_0000
   } mode_type;

   typedef struct packed {
      action_type  action;
      logic [1:0]  direction_index;
      logic [31:0] pattern;
      logic [1:0]  hold_seconds;
      logic        entered_green;
   } result_type;

   // One run of up to three beats, beat 0 in results[0]
   typedef struct packed {
      logic [1:0]                 count;
      result_type [MAX_BEATS-1:0] results;
   } run_type;

   function automatic result_type mk_result(action_type act, logic [1:0] idx,
                                            logic [31:0] pat, logic [1:0] hold,
                                            logic green);
      result_type r;
      r.action          = act;
      r.direction_index = idx;
      r.pattern         = pat;
      r.hold_seconds    = hold;
      r.entered_green   = green;
      return r;
   endfunction

endpackage

FILE: hw/rtl/mbmc_front.sv
// Front end: accepts request beats, keeps the mode state and builds one run per item.
// Depends on mbmc_pkg.
module mbmc_front #(
   parameter int DIRECTIONS = mbmc_pkg::DIRECTIONS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic              op,
   input  logic [5:0]        frame_type,
   input  logic [7:0]        button_bits,
   input  logic [31:0]       direction_pattern,
   input  logic              other_owner,
   input  logic              step_has_green,
   input  logic [7:0]        timeout_minutes,
   output logic              push,
   output mbmc_pkg::run_type push_run
);

   localparam int DirW = (DIRECTIONS > 2) ? $clog2(DIRECTIONS) : 1;
   localparam logic [DirW-1:0] DirLast = DirW'(DIRECTIONS - 1);

   mbmc_pkg::mode_type mode_ff, mode_in;
   logic               green_ff, green_in;
   logic [DirW-1:0]    dir_cnt_ff, dir_cnt_in;
   logic [31:0]        last_pat_ff, last_pat_in;
   logic [13:0]        idle_ff, idle_in;

   logic [13:0] idle_inc;
   logic [13:0] limit;
   logic [31:0] idx_ext;
   logic [31:0] dir_pat;
   logic [1:0]  n;
   mbmc_pkg::run_type run;

   assign idle_inc = (idle_ff < mbmc_pkg::IDLE_MAX) ? idle_ff + 14'd1 : idle_ff;
   assign limit    = 14'(timeout_minutes) * mbmc_pkg::SECS_PER_MIN;
   assign idx_ext  = 32'(dir_cnt_ff);
   // Directions beyond the fourth have no byte in the pattern
   assign dir_pat  = (idx_ext < 32'd4) ?
                     (mbmc_pkg::DIR_LAMPS << {idx_ext[1:0], 3'b000}) : 32'd0;

   always_comb begin
      mode_in     = mode_ff;
      green_in    = green_ff;
      dir_cnt_in  = dir_cnt_ff;
      last_pat_in = last_pat_ff;
      idle_in     = idle_ff;
      run         = '0;
      n           = 2'd0;
      if (accept) begin
         if (op) begin
            if (mode_ff != mbmc_pkg::MODE_AUTO) begin
               idle_in = idle_inc;
               if (idle_inc >= limit) begin
                  run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_AUTO, 2'd0, 32'd0,
                                                       2'd0, 1'b0);
                  n = n + 2'd1;
                  mode_in = mbmc_pkg::MODE_AUTO;
                  idle_in = 14'd0;
               end
            end
         end else if (!other_owner && frame_type == mbmc_pkg::FRAME_MANUAL) begin
            if (!button_bits[0]) begin
               if (mode_ff != mbmc_pkg::MODE_AUTO) begin
                  if (mode_ff == mbmc_pkg::MODE_DIR || mode_ff == mbmc_pkg::MODE_SPECIAL) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_DIR_GREEN, 2'd0,
                                                          last_pat_ff, 2'd2, 1'b0);
                     n = n + 2'd1;
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_DIR_AMBER, 2'd0,
                                                          last_pat_ff, 2'd3, 1'b0);
                     n = n + 2'd1;
                  end else if (mode_ff == mbmc_pkg::MODE_STEP) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STEP_AMBER, 2'd0,
                                                          32'd0, 2'd2, 1'b0);
                     n = n + 2'd1;
                  end
                  run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_AUTO, 2'd0, 32'd0,
                                                       2'd0, 1'b0);
                  n = n + 2'd1;
                  mode_in = mbmc_pkg::MODE_AUTO;
                  idle_in = 14'd0;
               end
            end else if (mode_ff == mbmc_pkg::MODE_AUTO) begin
               run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_ENTER, 2'd0, 32'd0,
                                                    2'd0, step_has_green);
               n = n + 2'd1;
               green_in    = step_has_green;
               last_pat_in = 32'd0;
               mode_in     = mbmc_pkg::MODE_MANUAL;
               idle_in     = 14'd0;
            end else begin
               idle_in = 14'd0;
               if (button_bits[1]) begin
                  if (mode_ff != mbmc_pkg::MODE_FLASH) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_FLASH, 2'd0, 32'd0,
                                                          2'd0, 1'b0);
                     n = n + 2'd1;
                     mode_in = mbmc_pkg::MODE_FLASH;
                  end
               end else if (button_bits[2]) begin
                  if (mode_ff != mbmc_pkg::MODE_RED) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_ALL_RED, 2'd0, 32'd0,
                                                          2'd0, 1'b0);
                     n = n + 2'd1;
                     mode_in = mbmc_pkg::MODE_RED;
                  end
               end else if (button_bits[3]) begin
                  if (mode_ff == mbmc_pkg::MODE_MANUAL || mode_ff == mbmc_pkg::MODE_STEP) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STEP, 2'd0, 32'd0,
                                                          2'd0, 1'b0);
                     n = n + 2'd1;
                     mode_in = mbmc_pkg::MODE_STEP;
                  end
               end else if (button_bits[4]) begin
                  if (mode_ff == mbmc_pkg::MODE_MANUAL || mode_ff == mbmc_pkg::MODE_STAGE) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STAGE, 2'd0, 32'd0,
                                                          2'd0, 1'b0);
                     n = n + 2'd1;
                     mode_in = mbmc_pkg::MODE_STAGE;
                  end
               end else if (button_bits[5] || direction_pattern != 32'd0) begin
                  // Close the green of the running step before switching direction
                  if (mode_ff == mbmc_pkg::MODE_MANUAL && green_ff) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STEP_AMBER, 2'd0,
                                                          32'd0, 2'd2, 1'b0);
                     n = n + 2'd1;
                  end else if (mode_ff == mbmc_pkg::MODE_STEP) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STEP_GREEN, 2'd0,
                                                          32'd0, 2'd2, 1'b0);
                     n = n + 2'd1;
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_STEP_AMBER, 2'd0,
                                                          32'd0, 2'd0, 1'b0);
                     n = n + 2'd1;
                  end
                  if (button_bits[5]) begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_DIR, idx_ext[1:0],
                                                          dir_pat, 2'd0, 1'b0);
                     n = n + 2'd1;
                     dir_cnt_in  = (dir_cnt_ff == DirLast) ? '0 : dir_cnt_ff + 1'b1;
                     last_pat_in = dir_pat;
                     mode_in     = mbmc_pkg::MODE_DIR;
                  end else begin
                     run.results[n] = mbmc_pkg::mk_result(mbmc_pkg::ACT_SPECIAL, 2'd0,
                                                          direction_pattern, 2'd0, 1'b0);
                     n = n + 2'd1;
                     last_pat_in = direction_pattern;
                     mode_in     = mbmc_pkg::MODE_SPECIAL;
                  end
               end
            end
         end
      end
      run.count = n;
   end

   assign push     = accept && (n != 2'd0);
   assign push_run = run;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= mbmc_pkg::MODE_AUTO;
         green_ff    <= 1'b0;
         dir_cnt_ff  <= '0;
         last_pat_ff <= 32'd0;
         idle_ff     <= 14'd0;
      end else begin
         mode_ff     <= mode_in;
         green_ff    <= green_in;
         dir_cnt_ff  <= dir_cnt_in;
         last_pat_ff <= last_pat_in;
         idle_ff     <= idle_in;
      end
   end

endmodule

FILE: hw/rtl/mbmc_queue.sv
// Short run queue between the front end and the beat sequencer.
// Depends on mbmc_pkg.
module mbmc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  mbmc_pkg::run_type push_run,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output mbmc_pkg::run_type head_run
);

   localparam int Depth = mbmc_pkg::QUEUE_DEPTH;
   localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW  = $clog2(Depth + 1);

   mbmc_pkg::run_type slot_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;

   assign full       = (cnt_ff == CntW'(Depth));
   assign head_valid = (cnt_ff != '0);
   assign head_run   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_run;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: hw/rtl/mbmc_back.sv
// Beat sequencer: one head run beat a cycle into the response register, if ready.
// Depends on mbmc_pkg.
module mbmc_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 head_valid,
   input  mbmc_pkg::run_type    head_run,
   output logic                 pop,
   output logic                 out_valid,
   input  logic                 out_ready,
   output mbmc_pkg::result_type out_result,
   output logic                 out_last
);

   logic [1:0]           beat_ff, beat_in;
   logic                 valid_ff, valid_in;
   mbmc_pkg::result_type result_ff;
   logic                 last_ff;
   logic                 load;
   logic                 final_beat;

   assign load       = head_valid && (!valid_ff || out_ready);
   assign final_beat = (beat_ff == head_run.count - 2'd1);
   assign pop        = load && final_beat;

   always_comb begin
      beat_in  = beat_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         beat_in  = final_beat ? 2'd0 : beat_ff + 2'd1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= head_run.results[beat_ff];
         last_ff   <= final_beat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff  <= beat_in;
         valid_ff <= valid_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
   assign out_last   = last_ff;

endmodule

FILE: hw/rtl/manual_button_mode_controller_core.sv
// Manual button mode controller top level: stream ports, timeout register, front/queue/back.
// Depends on mbmc_pkg, mbmc_front, mbmc_queue and mbmc_back.
//
// Each request beat is either a remote-button frame or a one-second tick. The front end
// takes a request beat every cycle while the two-entry run queue has room, updates the
// mode state at once and queues the run of zero to three actions the item causes; items
// that cause nothing leave no trace in the queue. The back end sends one response beat
// per cycle from its output register while rsp_tready allows, tlast on the final beat
// of a run; an item with several actions takes one beat per action, so the response
// port sets the sustained rate. An item's first response beat passes through a queue
// slot and then the output register. The idle timeout is timeout_minutes*60 ticks; the
// register sits at byte address 0 and resets to 5. Write it only while no run is pending.
module manual_button_mode_controller_core #(
   parameter int DIRECTIONS = mbmc_pkg::DIRECTIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // frame_type, button_bits, direction_pattern,
                                   // other_owner, step_has_green
   input  logic [0:0]  req_tuser,  // op
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // direction_index, pattern, hold_seconds,
                                   // entered_green, zero pad
   output logic [3:0]  rsp_tuser,  // action
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [7:0]           timeout_ff, timeout_in;
   logic                 accept;
   logic                 push;
   mbmc_pkg::run_type    push_run;
   logic                 full;
   logic                 pop;
   logic                 head_valid;
   mbmc_pkg::run_type    head_run;
   mbmc_pkg::result_type out_result;
   logic                 csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == mbmc_pkg::ADDR_TIMEOUT[2]);
   assign csr_prdata = csr_hit ? {24'd0, timeout_ff} : 32'd0;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         timeout_in = csr_pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= mbmc_pkg::TIMEOUT_RST;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   assign req_tready = !full;
   assign accept     = req_tvalid && req_tready;

   mbmc_front #(
      .DIRECTIONS (DIRECTIONS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .accept            (accept),
      .op                (req_tuser[0]),
      .frame_type        (req_tdata[5:0]),
      .button_bits       (req_tdata[13:6]),
      .direction_pattern (req_tdata[45:14]),
      .other_owner       (req_tdata[46]),
      .step_has_green    (req_tdata[47]),
      .timeout_minutes   (timeout_ff),
      .push              (push),
      .push_run          (push_run)
   );

   mbmc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_run   (push_run),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_run   (head_run)
   );

   mbmc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_run   (head_run),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_result (out_result),
      .out_last   (rsp_tlast)
   );

   assign rsp_tuser = out_result.action;
   assign rsp_tdata = {3'b000, out_result.entered_green, out_result.hold_seconds,
                       out_result.pattern, out_result.direction_index};

endmodule

FILE: test/mbmc_checker.sv
`timescale 1ns / 100ps
// Checker for the manual button mode controller: follows the request, response and register
// ports, predicts each run of actions and compares every response beat. Depends on mbmc_pkg.
module mbmc_checker #(
   parameter int DIRECTIONS = mbmc_pkg::DIRECTIONS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [47:0] req_tdata,
   input  logic [0:0]  req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [39:0] rsp_tdata,
   input  logic [3:0]  rsp_tuser,
   input  logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          pending
);
   import mbmc_pkg::*;

   localparam logic [7:0] BTN_MANUAL = 8'h01;
   localparam logic [7:0] BTN_FLASH  = 8'h02;
   localparam logic [7:0] BTN_RED    = 8'h04;
   localparam logic [7:0] BTN_STEP   = 8'h08;
   localparam logic [7:0] BTN_STAGE  = 8'h10;
   localparam logic [7:0] BTN_DIR    = 8'h20;
   localparam logic       OP_TICK    = 1'b1;

   typedef struct {
      action_type  action;
      logic [1:0]  dir_index;
      logic [31:0] pattern;
      logic [1:0]  hold;
      logic        green;
      logic        last;
   } action_beat_type;

   action_beat_type expected_actions[$];
   action_beat_type run_buf[0:2];
   int              run_len;

   // Predicted controller state
   logic [7:0]  timeout_min;
   mode_type    mode;
   logic        green_at_entry;
   int          dir_count;
   logic [31:0] last_pattern;
   logic [13:0] idle_secs;

   initial fail_count = 0;
   initial pending = 0;

   task automatic add_action(action_type act, logic [1:0] idx, logic [31:0] pat,
                             logic [1:0] hold, logic green);
      run_buf[run_len].action    = act;
      run_buf[run_len].dir_index = idx;
      run_buf[run_len].pattern   = pat;
      run_buf[run_len].hold      = hold;
      run_buf[run_len].green     = green;
      run_buf[run_len].last      = 1'b0;
      run_len++;
   endtask

   // Transition steps ahead of a direction or special direction
   task automatic add_lead_in();
      if (mode == MODE_MANUAL && green_at_entry) begin
         add_action(ACT_STEP_AMBER, 2'd0, 32'd0, 2'd2, 1'b0);
      end else if (mode == MODE_STEP) begin
         add_action(ACT_STEP_GREEN, 2'd0, 32'd0, 2'd2, 1'b0);
         add_action(ACT_STEP_AMBER, 2'd0, 32'd0, 2'd0, 1'b0);
      end
   endtask

   task automatic predict_actions(logic op, logic [5:0] ftype, logic [7:0] btn,
                                  logic [31:0] dpat, logic other, logic green);
      int          idx;
      logic [31:0] pat;
      run_len = 0;
      if (op == OP_TICK) begin
         if (mode != MODE_AUTO) begin
            if (idle_secs < IDLE_MAX) idle_secs++;
            if (int'(idle_secs) >= int'(timeout_min) * int'(SECS_PER_MIN)) begin
               add_action(ACT_AUTO, 2'd0, 32'd0, 2'd0, 1'b0);
               mode      = MODE_AUTO;
               idle_secs = '0;
            end
         end
      end else if (!other && ftype == FRAME_MANUAL) begin
         if ((btn & BTN_MANUAL) == 8'd0) begin
            if (mode != MODE_AUTO) begin
               if (mode == MODE_DIR || mode == MODE_SPECIAL) begin
                  add_action(ACT_DIR_GREEN, 2'd0, last_pattern, 2'd2, 1'b0);
                  add_action(ACT_DIR_AMBER, 2'd0, last_pattern, 2'd3, 1'b0);
               end else if (mode == MODE_STEP) begin
                  add_action(ACT_STEP_AMBER, 2'd0, 32'd0, 2'd2, 1'b0);
               end
               add_action(ACT_AUTO, 2'd0, 32'd0, 2'd0, 1'b0);
               mode      = MODE_AUTO;
               idle_secs = '0;
            end
         end else if (mode == MODE_AUTO) begin
            add_action(ACT_ENTER, 2'd0, 32'd0, 2'd0, green);
            green_at_entry = green;
            last_pattern   = '0;
            mode           = MODE_MANUAL;
            idle_secs      = '0;
         end else begin
            idle_secs = '0;
            if (btn & BTN_FLASH) begin
               if (mode != MODE_FLASH) begin
                  add_action(ACT_FLASH, 2'd0, 32'd0, 2'd0, 1'b0);
                  mode = MODE_FLASH;
               end
            end else if (btn & BTN_RED) begin
               if (mode != MODE_RED) begin
                  add_action(ACT_ALL_RED, 2'd0, 32'd0, 2'd0, 1'b0);
                  mode = MODE_RED;
               end
            end else if (btn & BTN_STEP) begin
               if (mode == MODE_MANUAL || mode == MODE_STEP) begin
                  add_action(ACT_STEP, 2'd0, 32'd0, 2'd0, 1'b0);
                  mode = MODE_STEP;
               end
            end else if (btn & BTN_STAGE) begin
               if (mode == MODE_MANUAL || mode == MODE_STAGE) begin
                  add_action(ACT_STAGE, 2'd0, 32'd0, 2'd0, 1'b0);
                  mode = MODE_STAGE;
               end
            end else if (btn & BTN_DIR) begin
               idx = dir_count % DIRECTIONS;
               pat = (idx < 4) ? (DIR_LAMPS << (8 * idx)) : 32'd0;
               add_lead_in();
               add_action(ACT_DIR, idx[1:0], pat, 2'd0, 1'b0);
               dir_count    = (idx + 1) % DIRECTIONS;
               last_pattern = pat;
               mode         = MODE_DIR;
            end else if (dpat != 32'd0) begin
               add_lead_in();
               add_action(ACT_SPECIAL, 2'd0, dpat, 2'd0, 1'b0);
               last_pattern = dpat;
               mode         = MODE_SPECIAL;
            end
         end
      end
      if (run_len > 0) run_buf[run_len-1].last = 1'b1;
      for (int i = 0; i < run_len; i++) expected_actions.push_back(run_buf[i]);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      action_beat_type want;
      if (reset) begin
         timeout_min    = TIMEOUT_RST;
         mode           = MODE_AUTO;
         green_at_entry = 1'b0;
         dir_count      = 0;
         last_pattern   = '0;
         idle_secs      = '0;
         expected_actions.delete();
         pending <= 0;
      end else begin
         // Compare the response beat before this edge's request can add to the queue
         if (rsp_tvalid && rsp_tready) begin
            if (expected_actions.size() == 0) begin
               $error("response beat with no action expected: action %0d", rsp_tuser);
               fail_count++;
            end else begin
               want = expected_actions.pop_front();
               check_field("action", 32'(want.action), 32'(rsp_tuser));
               check_field("direction_index", 32'(want.dir_index), 32'(rsp_tdata[1:0]));
               check_field("pattern", want.pattern, rsp_tdata[33:2]);
               check_field("hold_seconds", 32'(want.hold), 32'(rsp_tdata[35:34]));
               check_field("entered_green", 32'(want.green), 32'(rsp_tdata[36]));
               check_field("last", 32'(want.last), 32'(rsp_tlast));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr[2] == ADDR_TIMEOUT[2])
            timeout_min = csr_pwdata[7:0];
         if (req_tvalid && req_tready)
            predict_actions(req_tuser[0], req_tdata[5:0], req_tdata[13:6], req_tdata[45:14],
                            req_tdata[46], req_tdata[47]);
         pending <= expected_actions.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for manual_button_mode_controller_core: clock, reset, request and register
// stimulus, response back-pressure and the verdict. Depends on mbmc_pkg and mbmc_checker.
module tb_top;
   import mbmc_pkg::*;

   localparam int         RANDOM_PER_PHASE = 64;
   localparam int         PHASES           = 6;
   localparam int         HOLDOFF_CYCLES   = 60;
   localparam int         TIMEOUT_TICKS    = 62;
   localparam logic [7:0] BTN_MANUAL       = 8'h01;
   localparam logic [7:0] BTN_FLASH        = 8'h02;
   localparam logic [7:0] BTN_RED          = 8'h04;
   localparam logic [7:0] BTN_STEP         = 8'h08;
   localparam logic [7:0] BTN_STAGE        = 8'h10;
   localparam logic [7:0] BTN_DIR          = 8'h20;
   localparam logic       OP_FRAME         = 1'b0;
   localparam logic       OP_TICK          = 1'b1;
   localparam logic [2:0] ADDR_SPARE       = 3'h4;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata   = '0;
   logic [0:0]  req_tuser   = '0;
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [39:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   int fail_count;
   int pending;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int holdoff_asked = 0;
   int holdoff_taken = 0;
   int holdoff_left  = 0;

   int          phase_timeout [PHASES] = '{0, 1, 255, 2, 1, 0};
   int          phase_idle    [PHASES] = '{0, 82, 0, 28, 0, 82};
   int          phase_stall   [PHASES] = '{0, 0, 82, 28, 0, 0};

   manual_button_mode_controller_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mbmc_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // Response side: random stalls, or a long hold-off when the stimulus asks for one
   always @(negedge clock) begin
      if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (holdoff_taken != holdoff_asked) begin
         holdoff_taken <= holdoff_asked;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_item(logic op, logic [5:0] ftype, logic [7:0] btn, logic [31:0] dpat,
                            logic other, logic green);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {green, other, dpat, btn, ftype};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_frame(logic [7:0] btn, logic [31:0] dpat, logic green);
      send_item(OP_FRAME, FRAME_MANUAL, btn, dpat, 1'b0, green);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 6'($urandom()), 8'($urandom()), $urandom(), 1'($urandom()),
                1'($urandom()));
   endtask

   // Drop valid and hold until every expected action has come out
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   task automatic write_csr(logic [2:0] addr, logic [31:0] data);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic send_random();
      int          r;
      logic [7:0]  btn;
      logic [5:0]  ftype;
      logic [31:0] dpat;
      r     = $urandom_range(99);
      dpat  = ($urandom_range(3) == 0) ? 32'd0 : $urandom();
      btn   = 8'($urandom()) & 8'hC0;
      ftype = ($urandom_range(19) == 0) ? 6'($urandom()) : FRAME_MANUAL;
      if (r < 22) begin
         send_tick();
      end else if (r < 30) begin
         send_item(OP_FRAME, 6'($urandom()), 8'($urandom()), $urandom(), 1'($urandom()),
                   1'($urandom()));
      end else begin
         case ($urandom_range(9))
            0:       btn |= 8'h00;
            1:       btn |= BTN_MANUAL;
            2:       btn |= BTN_MANUAL | BTN_FLASH;
            3:       btn |= BTN_MANUAL | BTN_RED;
            4:       btn |= BTN_MANUAL | BTN_STEP;
            5:       btn |= BTN_MANUAL | BTN_STAGE;
            6, 7:    btn |= BTN_MANUAL | BTN_DIR;
            8:       btn |= 8'($urandom()) & 8'h3F | BTN_MANUAL;
            default: begin
               btn |= BTN_MANUAL;
               dpat = $urandom() | 32'h1;
            end
         endcase
         send_item(OP_FRAME, ftype, btn, dpat, ($urandom_range(19) == 0), 1'($urandom()));
      end
   endtask

   initial begin
      int guard;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part, timeout at its reset value
      send_item(OP_TICK, 6'h3F, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);   // tick in auto
      send_item(OP_FRAME, FRAME_MANUAL, 8'hFF, 32'hFFFF_FFFF, 1'b1, 1'b1);  // foreign owner
      send_item(OP_FRAME, 6'h3F, BTN_MANUAL, 32'h0, 1'b0, 1'b0);     // not a manual frame
      send_frame(8'hC0, 32'h1234_5678, 1'b0);                        // manual clear in auto
      send_frame(BTN_MANUAL, 32'h0, 1'b1);                           // enter, green
      send_tick();
      send_frame(BTN_MANUAL | BTN_DIR, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_DIR, 32'h0, 1'b0);
      send_frame(8'h00, 32'h0, 1'b0);                                // leave from direction
      send_frame(8'hFF, 32'hFFFF_FFFF, 1'b0);                        // enter, amber
      send_frame(BTN_MANUAL | BTN_STEP, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_STEP, 32'h0, 1'b0);
      send_frame(BTN_MANUAL, 32'hFFFF_FFFF, 1'b0);                   // special from step
      send_frame(BTN_MANUAL | BTN_STAGE, 32'h0, 1'b0);               // stage not allowed
      send_frame(BTN_MANUAL | BTN_FLASH, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_FLASH, 32'h0, 1'b0);               // repeated flash
      send_frame(BTN_MANUAL | BTN_RED, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_RED, 32'h0, 1'b0);                 // repeated all red
      send_frame(BTN_MANUAL | BTN_STEP, 32'h0, 1'b0);                // step not allowed
      send_frame(BTN_MANUAL, 32'h0, 1'b0);                           // no button
      send_frame(8'h00, 32'h0, 1'b0);
      send_frame(BTN_MANUAL, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_STAGE, 32'h0, 1'b0);
      send_frame(BTN_MANUAL | BTN_STEP, 32'h0, 1'b0);                // step not allowed
      send_frame(BTN_MANUAL | BTN_DIR, 32'h0, 1'b0);
      send_frame(8'h00, 32'h0, 1'b0);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         repeat (8) @(negedge clock);
         if (p == 2) write_csr(ADDR_SPARE, $urandom());
         write_csr(ADDR_TIMEOUT, ($urandom() & 32'hFFFF_FF00) | 32'(phase_timeout[p]));
         send_idle_pct = phase_idle[p];
         stall_pct     = phase_stall[p];
         for (int k = 0; k < RANDOM_PER_PHASE; k++) begin
            if (p == 4 && (k == 20 || k == 55)) holdoff_asked++;
            if (p == 3 && k == 40) drain();
            // Enter or stay in manual, then tick through the one-minute idle timeout
            if (p == 4 && k == 40) begin
               send_frame(BTN_MANUAL, 32'h0, 1'b0);
               repeat (TIMEOUT_TICKS) send_tick();
            end
            send_random();
         end
      end

      drain();
      send_idle_pct = 0;
      stall_pct     = 0;
      guard = 0;
      while (pending != 0 && guard < 5000) begin
         @(negedge clock);
         guard++;
      end
      repeat (20) @(negedge clock);
      if (pending != 0) $error("actions still expected at the end: %0d", pending);
      if (fail_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("tb: failure");
      $finish;
   end

endmodule
